/* rtl/core/mpsm_pkg.sv */
// shared constants and types for the multi-pattern string matcher
package mpsm_pkg;

   localparam int MAX_STATES = 1024;
   localparam int ALPHABET   = 256;
   localparam int SLOTS      = 8;
   localparam int MAX_TEXT   = 65536;

   localparam int STATE_W = $clog2(MAX_STATES);
   localparam int SYM_W   = $clog2(ALPHABET);
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TADDR_W = STATE_W + SYM_W;
   localparam int POS_W   = $clog2(MAX_TEXT);
   localparam int PAT_W   = 10;
   localparam int LEN_W   = 8;
   localparam int START_W = 16;

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

   localparam logic [1:0] KIND_SCAN  = 2'd0;
   localparam logic [1:0] KIND_TRANS = 2'd1;
   localparam logic [1:0] KIND_SLOT  = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [PAT_W-1:0] pattern;
      logic [LEN_W-1:0] length;
   } slot_type;

   typedef slot_type [SLOTS-1:0] row_type;
   typedef logic [SLOTS-1:0] slot_mask_type;

   typedef struct packed {
      logic             any;
      logic             last;
      logic [PAT_W-1:0] pattern;
      logic [LEN_W-1:0] length;
      slot_mask_type    rest;
   } sel_type;

endpackage

/* rtl/core/mpsm_slot_sel.sv */
// picks the lowest pending valid match slot of a row
module mpsm_slot_sel (
   input  mpsm_pkg::row_type       row,
   input  mpsm_pkg::slot_mask_type pend,
   output mpsm_pkg::sel_type       sel
);
   import mpsm_pkg::*;

   slot_mask_type eff;
   slot_mask_type pick;
   logic          found;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         eff[i] = pend[i] & row[i].valid;
      end
      pick        = '0;
      found       = 1'b0;
      sel.pattern = '0;
      sel.length  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (eff[i] && !found) begin
            found       = 1'b1;
            pick[i]     = 1'b1;
            sel.pattern = row[i].pattern;
            sel.length  = row[i].length;
         end
      end
      sel.any  = found;
      sel.rest = eff & ~pick;
      sel.last = (sel.rest == '0);
   end

endmodule

/* rtl/core/multi_pattern_string_matcher_core.sv */
// automaton search core: transition table and match slot rows in block memories
// scan transfer: transition read, then row read, then the first result is registered; a scan
//   holds the input until it has emitted one result per valid match slot (or one no-match
//   result), and each output stall holds it longer
// table and slot write transfers are written on acceptance in ST_IDLE; kind 3 transfers are dropped
// reset (synchronous): state, position and fold register reset; then a pass in ST_CLEAR
//   clears every match row, during which no input transfer is taken
module multi_pattern_string_matcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,     // case_fold
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,     // byte_value, state_index, next_state, slot_index,
                                      // slot_valid, slot_pattern, slot_length, zero fill
   input  logic [1:0]  req_tuser,     // kind
   input  logic        req_tlast,     // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // pattern_number, match_start, position_saturated,
                                      // zero fill
   output logic        rsp_tuser,     // match_found
   output logic        rsp_tlast      // last_result
);
   import mpsm_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_EMIT} state_type;

   state_type state_ff, state_in;

   logic [STATE_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [STATE_W-1:0] cur_state_ff, cur_state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               fold_ff;
   logic [POS_W-1:0]   item_pos_ff, item_pos_in;
   logic               item_sat_ff, item_sat_in;
   logic               item_last_ff, item_last_in;
   slot_mask_type      pend_ff, pend_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [PAT_W-1:0]   rsp_pat_ff, rsp_pat_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;
   logic               rsp_sat_ff, rsp_sat_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [STATE_W-1:0] tr_mem [MAX_STATES*ALPHABET];
   logic [STATE_W-1:0] tr_rd_ff;
   row_type            mt_mem [MAX_STATES];
   row_type            mt_rd_ff;

   logic [7:0]         in_byte;
   logic [STATE_W-1:0] in_state;
   logic [STATE_W-1:0] in_next;
   logic [SLOT_W-1:0]  in_slot;
   slot_type           in_slot_data;
   logic [7:0]         sym_byte;
   logic [TADDR_W-1:0] tr_addr;
   logic               acc;
   logic               tr_wr, tr_rd, mt_wr, mt_rd, clr_wr;
   logic               out_free;
   sel_type            sel;

   assign in_byte              = req_tdata[7:0];
   assign in_state             = req_tdata[17:8];
   assign in_next              = req_tdata[27:18];
   assign in_slot              = req_tdata[30:28];
   assign in_slot_data.valid   = req_tdata[31];
   assign in_slot_data.pattern = req_tdata[41:32];
   assign in_slot_data.length  = req_tdata[49:42];

   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (fold_ff && (in_byte inside {[8'h61:8'h7A]})) begin
         sym_byte = in_byte - 8'h20;
      end else begin
         sym_byte = in_byte;
      end
   end

   always_comb begin
      tr_wr   = acc && (req_tuser == KIND_TRANS);
      tr_rd   = acc && (req_tuser == KIND_SCAN);
      mt_wr   = acc && (req_tuser == KIND_SLOT);
      mt_rd   = (state_ff == ST_LOOKUP);
      clr_wr  = (state_ff == ST_CLEAR);
      if (tr_wr) begin
         tr_addr = {in_state, in_byte[SYM_W-1:0]};
      end else begin
         tr_addr = {cur_state_ff, sym_byte[SYM_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (tr_wr) begin
         tr_mem[tr_addr] <= in_next;
      end
      if (tr_rd) begin
         tr_rd_ff <= tr_mem[tr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_wr) begin
         mt_mem[clr_cnt_ff] <= '0;
      end else if (mt_wr) begin
         mt_mem[in_state][in_slot] <= in_slot_data;
      end
      if (mt_rd) begin
         mt_rd_ff <= mt_mem[tr_rd_ff];
      end
   end

   mpsm_slot_sel u_sel (
      .row  (mt_rd_ff),
      .pend (pend_ff),
      .sel  (sel)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cur_state_in = cur_state_ff;
      pos_in       = pos_ff;
      item_pos_in  = item_pos_ff;
      item_sat_in  = item_sat_ff;
      item_last_in = item_last_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_pat_in   = rsp_pat_ff;
      rsp_start_in = rsp_start_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == STATE_W'(MAX_STATES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (tr_rd) begin
               item_pos_in  = pos_ff;
               item_sat_in  = (pos_ff == POS_MAX);
               item_last_in = req_tlast;
               if (req_tlast) begin
                  pos_in = '0;
               end else if (pos_ff != POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cur_state_in = item_last_ff ? '0 : tr_rd_ff;
            pend_in      = '1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = sel.any;
               rsp_sat_in   = item_sat_ff;
               rsp_last_in  = sel.last;
               pend_in      = sel.rest;
               if (sel.any) begin
                  rsp_pat_in   = sel.pattern;
                  rsp_start_in = START_W'(item_pos_ff - POS_W'(sel.length) + 1'b1);
               end else begin
                  rsp_pat_in   = '0;
                  rsp_start_in = '0;
               end
               if (sel.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cur_state_ff <= '0;
         pos_ff       <= '0;
         fold_ff      <= 1'b1;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cur_state_ff <= cur_state_in;
         pos_ff       <= pos_in;
         if (csr_we) begin
            fold_ff <= csr_wdata;
         end
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_pos_ff  <= item_pos_in;
      item_sat_ff  <= item_sat_in;
      item_last_ff <= item_last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pat_ff   <= rsp_pat_in;
      rsp_start_ff <= rsp_start_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_sat_ff, rsp_start_ff, rsp_pat_ff};

endmodule
